### design/bco_pkg.sv
// ----------------------------------------------------------------------------
// bco_pkg
// Shared constants and types for the box / circle overlap test pipeline.
// ----------------------------------------------------------------------------
package bco_pkg;

  // Width of a box size or circle radius field.
  localparam int EXT_W = 20;
  // Width of a sum of two extents.
  localparam int WS_W = EXT_W + 1;
  // Width of a radius at doubled scale, including the sum of two radii.
  localparam int RR_W = EXT_W + 2;
  // Width of a squared distance or squared radius.
  localparam int SQ_W = 2 * RR_W;
  // Number of register stages from input beat to output beat.
  localparam int NUM_STAGES = 5;

  // Shape pair codes, first shape in the high bit (0 box, 1 circle).
  localparam logic [1:0] PAIR_BOX_BOX       = 2'b00;
  localparam logic [1:0] PAIR_BOX_CIRCLE    = 2'b01;
  localparam logic [1:0] PAIR_CIRCLE_BOX    = 2'b10;
  localparam logic [1:0] PAIR_CIRCLE_CIRCLE = 2'b11;

  // Per-axis distance excess and flags handed from the geometry stages
  // to the distance stages.
  typedef struct packed {
    logic [RR_W-1:0] ex;        // x distance beyond the box, valid when near
    logic [RR_W-1:0] ey;        // y distance beyond the box, valid when near
    logic [RR_W-1:0] rr;        // radius at doubled scale
    logic            box_hit;   // interval overlap on both axes
    logic            near;      // both excesses within the radius
    logic            box_pair;  // both shapes are boxes
    logic            live;      // both enabled and no degenerate box pair
  } bco_near_t;

endpackage

### design/box_circle_overlap_test.sv
// ----------------------------------------------------------------------------
// box_circle_overlap_test
// Overlap test between two 2D shapes, each an axis-aligned box or a circle.
// ----------------------------------------------------------------------------
// Each input beat carries one shape pair and yields one output beat with the
// overlap bit. The block is a five-stage pipeline: a new pair is taken every
// cycle while the pipeline is not full and stalled. Each stage has its own
// valid bit and holds only while the stage after it is full and stalled, so
// bubbles are squeezed out and a waiting result stops new beats only once
// every stage is full. The widest step is the 22 by 22 bit squaring in
// stage four.
// ----------------------------------------------------------------------------
module box_circle_overlap_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // From bit 0: first_center_x, first_center_y, first_extent_x,
  // first_extent_y, second_center_x, second_center_y, second_extent_x,
  // second_extent_y, zero fill.
  input  logic [((4*COORD_BITS+4*bco_pkg::EXT_W+7)/8)*8-1:0] in_tdata,
  // From bit 0: first_is_circle, second_is_circle, enable_bits[1:0].
  input  logic [3:0]              in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // From bit 0: overlap, zero fill.
  output logic [7:0]              out_tdata
);

  localparam int C = COORD_BITS;
  localparam int E = bco_pkg::EXT_W;
  localparam int N = bco_pkg::NUM_STAGES;

  logic [N-1:0]        valid_r, valid_nxt, stage_en;
  bco_pkg::bco_near_t  near;
  logic                overlap;

  // Stage enables: a stage loads when it is empty or the next one loads.
  always_comb begin
    stage_en[N-1] = !valid_r[N-1] || out_tready;
    for (int k = N - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  // Valid bits follow the data down the pipeline.
  always_comb begin
    valid_nxt[0] = stage_en[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < N; k++) begin
      valid_nxt[k] = stage_en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready = stage_en[0];

  // Geometry stages.
  bco_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk              (clk),
    .stage_en         (stage_en[2:0]),
    .first_is_circle  (in_tuser[0]),
    .second_is_circle (in_tuser[1]),
    .enable_bits      (in_tuser[3:2]),
    .first_center_x   (in_tdata[C-1:0]),
    .first_center_y   (in_tdata[2*C-1:C]),
    .first_extent_x   (in_tdata[2*C+E-1:2*C]),
    .first_extent_y   (in_tdata[2*C+2*E-1:2*C+E]),
    .second_center_x  (in_tdata[3*C+2*E-1:2*C+2*E]),
    .second_center_y  (in_tdata[4*C+2*E-1:3*C+2*E]),
    .second_extent_x  (in_tdata[4*C+3*E-1:4*C+2*E]),
    .second_extent_y  (in_tdata[4*C+4*E-1:4*C+3*E]),
    .near_out         (near)
  );

  // Distance stages and result register.
  bco_dist u_dist (
    .clk      (clk),
    .stage_en (stage_en[4:3]),
    .near_in  (near),
    .overlap  (overlap)
  );

  assign out_tvalid = valid_r[N-1];
  assign out_tdata  = {7'b0, overlap};

endmodule

### design/bco_geom.sv
// ----------------------------------------------------------------------------
// bco_geom
// Geometry stages: center differences and extent selection, absolute
// values, then distance excess beyond the box and the early radius check.
// ----------------------------------------------------------------------------
module bco_geom #(
  parameter int COORD_BITS = 24
) (
  input  logic                                  clk,
  input  logic [2:0]                            stage_en,
  input  logic                                  first_is_circle,
  input  logic                                  second_is_circle,
  input  logic [1:0]                            enable_bits,
  input  logic [COORD_BITS-1:0]                 first_center_x,
  input  logic [COORD_BITS-1:0]                 first_center_y,
  input  logic [bco_pkg::EXT_W-1:0]             first_extent_x,
  input  logic [bco_pkg::EXT_W-1:0]             first_extent_y,
  input  logic [COORD_BITS-1:0]                 second_center_x,
  input  logic [COORD_BITS-1:0]                 second_center_y,
  input  logic [bco_pkg::EXT_W-1:0]             second_extent_x,
  input  logic [bco_pkg::EXT_W-1:0]             second_extent_y,
  output bco_pkg::bco_near_t                    near_out
);

  // Doubled-scale difference width and the width used for the excess.
  localparam int D_W = COORD_BITS + 2;
  localparam int X_W = (D_W > bco_pkg::RR_W) ? D_W : bco_pkg::RR_W;

  // Stage 1 signals.
  logic signed [D_W-1:0]           dx_nxt, dy_nxt, dx_r, dy_r;
  logic [bco_pkg::WS_W-1:0]        wx_nxt, wy_nxt, wx1_r, wy1_r;
  logic [bco_pkg::RR_W-1:0]        rr_nxt, rr1_r;
  logic [bco_pkg::WS_W-1:0]        rsum;
  logic                            bb_nxt, live_nxt, bb1_r, live1_r;
  logic                            nonzero;

  // Stage 2 signals.
  logic [D_W-1:0]                  ax_nxt, ay_nxt, ax2_r, ay2_r;
  logic [bco_pkg::WS_W-1:0]        wx2_r, wy2_r;
  logic [bco_pkg::RR_W-1:0]        rr2_r;
  logic                            bb2_r, live2_r;

  // Stage 3 signals.
  logic [X_W-1:0]                  axe, aye, wxe, wye, rre, exe, eye;
  bco_pkg::bco_near_t              near_nxt, near_r;

  // Stage 1: doubled center differences, first minus second.
  assign dx_nxt = {first_center_x[COORD_BITS-1], first_center_x, 1'b0}
                - {second_center_x[COORD_BITS-1], second_center_x, 1'b0};
  assign dy_nxt = {first_center_y[COORD_BITS-1], first_center_y, 1'b0}
                - {second_center_y[COORD_BITS-1], second_center_y, 1'b0};

  assign rsum    = bco_pkg::WS_W'(first_extent_x) + bco_pkg::WS_W'(second_extent_x);
  assign nonzero = (|first_extent_x) && (|first_extent_y)
                && (|second_extent_x) && (|second_extent_y);

  // Stage 1: pick the box half-span and the radius for the shape pair.
  always_comb begin
    wx_nxt = '0;
    wy_nxt = '0;
    rr_nxt = '0;
    bb_nxt = 1'b0;
    case ({first_is_circle, second_is_circle})
      bco_pkg::PAIR_BOX_BOX: begin
        wx_nxt = bco_pkg::WS_W'(first_extent_x) + bco_pkg::WS_W'(second_extent_x);
        wy_nxt = bco_pkg::WS_W'(first_extent_y) + bco_pkg::WS_W'(second_extent_y);
        bb_nxt = 1'b1;
      end
      bco_pkg::PAIR_BOX_CIRCLE: begin
        wx_nxt = bco_pkg::WS_W'(first_extent_x);
        wy_nxt = bco_pkg::WS_W'(first_extent_y);
        rr_nxt = {1'b0, second_extent_x, 1'b0};
      end
      bco_pkg::PAIR_CIRCLE_BOX: begin
        wx_nxt = bco_pkg::WS_W'(second_extent_x);
        wy_nxt = bco_pkg::WS_W'(second_extent_y);
        rr_nxt = {1'b0, first_extent_x, 1'b0};
      end
      default: begin
        rr_nxt = {rsum, 1'b0};
      end
    endcase
  end

  // A box pair with any zero size never overlaps.
  assign live_nxt = (enable_bits == 2'b11) && (!bb_nxt || nonzero);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      wx1_r   <= wx_nxt;
      wy1_r   <= wy_nxt;
      rr1_r   <= rr_nxt;
      bb1_r   <= bb_nxt;
      live1_r <= live_nxt;
    end
  end

  // Stage 2: absolute differences. The most negative value maps to its
  // correct magnitude when read as unsigned.
  assign ax_nxt = dx_r[D_W-1] ? D_W'(-dx_r) : D_W'(dx_r);
  assign ay_nxt = dy_r[D_W-1] ? D_W'(-dy_r) : D_W'(dy_r);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      ax2_r   <= ax_nxt;
      ay2_r   <= ay_nxt;
      wx2_r   <= wx1_r;
      wy2_r   <= wy1_r;
      rr2_r   <= rr1_r;
      bb2_r   <= bb1_r;
      live2_r <= live1_r;
    end
  end

  // Stage 3: distance from the center to the box edge, clamped at zero.
  assign axe = X_W'(ax2_r);
  assign aye = X_W'(ay2_r);
  assign wxe = X_W'(wx2_r);
  assign wye = X_W'(wy2_r);
  assign rre = X_W'(rr2_r);
  assign exe = (axe > wxe) ? (axe - wxe) : '0;
  assign eye = (aye > wye) ? (aye - wye) : '0;

  always_comb begin
    near_nxt.ex       = exe[bco_pkg::RR_W-1:0];
    near_nxt.ey       = eye[bco_pkg::RR_W-1:0];
    near_nxt.rr       = rr2_r;
    near_nxt.box_hit  = (axe < wxe) && (aye < wye);
    near_nxt.near     = (exe <= rre) && (eye <= rre);
    near_nxt.box_pair = bb2_r;
    near_nxt.live     = live2_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      near_r <= near_nxt;
    end
  end

  assign near_out = near_r;

endmodule

### design/bco_dist.sv
// ----------------------------------------------------------------------------
// bco_dist
// Distance stages: squares of the per-axis excess and of the radius, then
// the final compare and the overlap result register.
// ----------------------------------------------------------------------------
module bco_dist (
  input  logic                            clk,
  // Bit 0 loads stage four, bit 1 loads stage five.
  input  logic [1:0]                      stage_en,
  input  bco_pkg::bco_near_t              near_in,
  output logic                            overlap
);

  logic [bco_pkg::SQ_W-1:0] sqx_nxt, sqy_nxt, rr2_nxt;
  logic [bco_pkg::SQ_W-1:0] sqx_r, sqy_r, rr2_r;
  logic                     box_hit_r, near_r, box_pair_r, live_r;
  logic [bco_pkg::SQ_W:0]   dist_sum;
  logic                     overlap_nxt, overlap_r;

  // Stage 4: three squares of 22-bit values.
  assign sqx_nxt = bco_pkg::SQ_W'(near_in.ex) * bco_pkg::SQ_W'(near_in.ex);
  assign sqy_nxt = bco_pkg::SQ_W'(near_in.ey) * bco_pkg::SQ_W'(near_in.ey);
  assign rr2_nxt = bco_pkg::SQ_W'(near_in.rr) * bco_pkg::SQ_W'(near_in.rr);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sqx_r      <= sqx_nxt;
      sqy_r      <= sqy_nxt;
      rr2_r      <= rr2_nxt;
      box_hit_r  <= near_in.box_hit;
      near_r     <= near_in.near;
      box_pair_r <= near_in.box_pair;
      live_r     <= near_in.live;
    end
  end

  // Stage 5: squared distance against squared radius, then the final pick.
  assign dist_sum = (bco_pkg::SQ_W+1)'(sqx_r) + (bco_pkg::SQ_W+1)'(sqy_r);
  assign overlap_nxt = live_r
                    && (box_pair_r ? box_hit_r
                                   : (near_r && (dist_sum <= (bco_pkg::SQ_W+1)'(rr2_r))));

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign overlap = overlap_r;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the box / circle overlap pipeline.
// ----------------------------------------------------------------------------
// Shape pairs go in on the input stream, and an overlap bit comes back on the
// result stream for every pair. The bench keeps its own 64-bit model of the
// geometry at doubled scale and compares every result beat, in order, with
// the bit that this model predicts. A directed block covers disabled shapes,
// touching and degenerate boxes, tangent circles and extreme coordinates.
// Random pairs follow in four traffic phases, with a mix of near-miss,
// exact-boundary and fully random geometry.
// ----------------------------------------------------------------------------
module tb;

  localparam int COORD_W    = 24;
  localparam int EXT_W      = bco_pkg::EXT_W;
  localparam int TDATA_W    = ((4*COORD_W + 4*EXT_W + 7) / 8) * 8;
  localparam int RESET_CYC  = 10;
  localparam int TIMEOUT_NS = 10_000_000;
  localparam int PHASE_LEN  = 370;

  // Enable codes: bit 0 first shape, bit 1 second shape.
  localparam logic [1:0] NONE_ENABLED   = 2'b00;
  localparam logic [1:0] FIRST_ENABLED  = 2'b01;
  localparam logic [1:0] SECOND_ENABLED = 2'b10;
  localparam logic [1:0] BOTH_ENABLED   = 2'b11;

  // One shape pair as carried by an input beat.
  typedef struct {
    logic                      first_circle;
    logic                      second_circle;
    logic [1:0]                enable;
    logic signed [COORD_W-1:0] first_cx;
    logic signed [COORD_W-1:0] first_cy;
    logic [EXT_W-1:0]          first_ex;
    logic [EXT_W-1:0]          first_ey;
    logic signed [COORD_W-1:0] second_cx;
    logic signed [COORD_W-1:0] second_cy;
    logic [EXT_W-1:0]          second_ex;
    logic [EXT_W-1:0]          second_ey;
  } shape_pair_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic [3:0]         in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int          err_count       = 0;

  // Predicted overlap bits, oldest first.
  bit overlap_expected_q[$];

  box_circle_overlap_test #(
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Geometry model, all values at doubled scale.
  // ---------------------------------------------------------------------------

  function automatic bit in_radius(longint dx, longint dy, longint rr);
    longint ax;
    longint ay;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    // A component beyond the radius settles it before any squaring.
    if (ax > rr || ay > rr) return 1'b0;
    return (ax * ax + ay * ay) <= (rr * rr);
  endfunction

  function automatic bit box_circle_hit(longint bx, longint by, longint w, longint h,
                                        longint cx, longint cy, longint rr);
    longint px;
    longint py;
    // Nearest point of the box to the circle center.
    px = (cx < bx - w) ? bx - w : ((cx > bx + w) ? bx + w : cx);
    py = (cy < by - h) ? by - h : ((cy > by + h) ? by + h : cy);
    return in_radius(cx - px, cy - py, rr);
  endfunction

  function automatic bit box_box_hit(longint ax, longint ay, longint aw, longint ah,
                                     longint bx, longint by, longint bw, longint bh);
    longint lo_x;
    longint hi_x;
    longint lo_y;
    longint hi_y;
    lo_x = (ax - aw > bx - bw) ? ax - aw : bx - bw;
    hi_x = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    lo_y = (ay - ah > by - bh) ? ay - ah : by - bh;
    hi_y = (ay + ah < by + bh) ? ay + ah : by + bh;
    return (lo_x < hi_x) && (lo_y < hi_y);
  endfunction

  function automatic bit predict_overlap(shape_pair_t p);
    longint x1;
    longint y1;
    longint w1;
    longint h1;
    longint x2;
    longint y2;
    longint w2;
    longint h2;
    x1 = 2 * longint'(p.first_cx);
    y1 = 2 * longint'(p.first_cy);
    w1 = longint'(p.first_ex);
    h1 = longint'(p.first_ey);
    x2 = 2 * longint'(p.second_cx);
    y2 = 2 * longint'(p.second_cy);
    w2 = longint'(p.second_ex);
    h2 = longint'(p.second_ey);
    if (p.enable != BOTH_ENABLED) return 1'b0;
    case ({p.first_circle, p.second_circle})
      bco_pkg::PAIR_BOX_BOX:    return box_box_hit(x1, y1, w1, h1, x2, y2, w2, h2);
      bco_pkg::PAIR_BOX_CIRCLE: return box_circle_hit(x1, y1, w1, h1, x2, y2, 2 * w2);
      bco_pkg::PAIR_CIRCLE_BOX: return box_circle_hit(x2, y2, w2, h2, x1, y1, 2 * w1);
      default:                  return in_radius(x1 - x2, y1 - y2, 2 * (w1 + w2));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Pair construction.
  // ---------------------------------------------------------------------------

  function automatic shape_pair_t make_pair(logic [1:0] kind, logic [1:0] en,
                                            int ax, int ay, int aw, int ah,
                                            int bx, int by, int bw, int bh);
    shape_pair_t p;
    {p.first_circle, p.second_circle} = kind;
    p.enable    = en;
    p.first_cx  = ax[COORD_W-1:0];
    p.first_cy  = ay[COORD_W-1:0];
    p.first_ex  = aw[EXT_W-1:0];
    p.first_ey  = ah[EXT_W-1:0];
    p.second_cx = bx[COORD_W-1:0];
    p.second_cy = by[COORD_W-1:0];
    p.second_ex = bw[EXT_W-1:0];
    p.second_ey = bh[EXT_W-1:0];
    return p;
  endfunction

  // Extent with a random bit length, so small and large sizes both show up.
  function automatic logic [EXT_W-1:0] rand_extent();
    return EXT_W'($urandom) & EXT_W'((1 << $urandom_range(EXT_W)) - 1);
  endfunction

  function automatic int rand_sign();
    return $urandom_range(1) ? 1 : -1;
  endfunction

  // Random pair: fully random, near each other, or right on a boundary.
  function automatic shape_pair_t rand_pair();
    shape_pair_t p;
    int unsigned mode;
    int reach1;
    int reach2;
    int span_x;
    int span_y;
    int dx;
    int dy;
    int k;
    int adj;
    int r1;
    mode = $urandom_range(9);
    p.first_circle  = $urandom_range(1);
    p.second_circle = $urandom_range(1);
    p.enable        = ($urandom_range(99) < 85) ? BOTH_ENABLED : 2'($urandom_range(3));
    p.first_cx      = COORD_W'($urandom);
    p.first_cy      = COORD_W'($urandom);
    p.first_ex      = EXT_W'($urandom);
    p.first_ey      = EXT_W'($urandom);
    p.second_cx     = COORD_W'($urandom);
    p.second_cy     = COORD_W'($urandom);
    p.second_ex     = EXT_W'($urandom);
    p.second_ey     = EXT_W'($urandom);
    if (mode >= 3 && mode < 8) begin
      // Near pair: offset spread around the sum of the reaches.
      p.first_ex = rand_extent();
      p.first_ey = rand_extent();
      p.second_ex = rand_extent();
      p.second_ey = rand_extent();
      reach1 = int'(p.first_ex);
      reach2 = int'(p.second_ex);
      span_x = reach1 + reach2 + reach1 / 4 + reach2 / 4 + 2;
      reach1 = p.first_circle ? int'(p.first_ex) : int'(p.first_ey);
      reach2 = p.second_circle ? int'(p.second_ex) : int'(p.second_ey);
      span_y = reach1 + reach2 + reach1 / 4 + reach2 / 4 + 2;
      dx = int'($urandom_range(2 * span_x)) - span_x;
      dy = int'($urandom_range(2 * span_y)) - span_y;
      p.second_cx = p.first_cx + dx[COORD_W-1:0];
      p.second_cy = p.first_cy + dy[COORD_W-1:0];
    end else if (mode >= 8) begin
      // Boundary pair: a 3-4-5 triangle or touching edges, give or take one.
      k   = $urandom_range(1, 50000);
      adj = int'($urandom_range(2)) - 1;
      case ({p.first_circle, p.second_circle})
        bco_pkg::PAIR_BOX_BOX: begin
          p.first_ex  = EXT_W'(2 * $urandom_range((1 << (EXT_W - 1)) - 1));
          p.second_ex = EXT_W'(2 * $urandom_range((1 << (EXT_W - 1)) - 1));
          p.first_ey  = rand_extent();
          p.second_ey = rand_extent();
          dx = (int'(p.first_ex) + int'(p.second_ex)) / 2 + adj;
          dy = 0;
        end
        bco_pkg::PAIR_CIRCLE_CIRCLE: begin
          r1 = $urandom_range(5 * k - 1);
          p.first_ex  = EXT_W'(r1);
          p.second_ex = EXT_W'(5 * k - r1 + adj);
          dx = 3 * k;
          dy = 4 * k;
        end
        bco_pkg::PAIR_BOX_CIRCLE: begin
          p.first_ex  = EXT_W'(2 * $urandom_range((1 << (EXT_W - 1)) - 1));
          p.first_ey  = EXT_W'(2 * $urandom_range((1 << (EXT_W - 1)) - 1));
          p.second_ex = EXT_W'(5 * k + adj);
          dx = int'(p.first_ex) / 2 + 3 * k;
          dy = int'(p.first_ey) / 2 + 4 * k;
        end
        default: begin
          p.second_ex = EXT_W'(2 * $urandom_range((1 << (EXT_W - 1)) - 1));
          p.second_ey = EXT_W'(2 * $urandom_range((1 << (EXT_W - 1)) - 1));
          p.first_ex  = EXT_W'(5 * k + adj);
          dx = int'(p.second_ex) / 2 + 3 * k;
          dy = int'(p.second_ey) / 2 + 4 * k;
        end
      endcase
      dx = dx * rand_sign();
      dy = dy * rand_sign();
      p.second_cx = p.first_cx + dx[COORD_W-1:0];
      p.second_cy = p.first_cy + dy[COORD_W-1:0];
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Called and returning at a falling edge.
  // ---------------------------------------------------------------------------

  task automatic send_pair(input shape_pair_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'({p.second_ey, p.second_ex, p.second_cy, p.second_cx,
                           p.first_ey, p.first_ex, p.first_cy, p.first_cx});
    in_tuser  <= {p.enable, p.second_circle, p.first_circle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    overlap_expected_q.push_back(predict_overlap(p));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (overlap_expected_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and the in-order result check.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (overlap_expected_q.size() == 0) begin
        $display("[%0t] unexpected result beat, expected none, got overlap %0b",
                 $time, out_tdata[0]);
        err_count++;
      end else begin
        if (out_tdata[0] !== overlap_expected_q[0]) begin
          $display("[%0t] overlap mismatch, expected %0b, got %0b",
                   $time, overlap_expected_q[0], out_tdata[0]);
          err_count++;
        end
        void'(overlap_expected_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    // Disabled shapes never hit, even when fully overlapping.
    send_pair(make_pair(bco_pkg::PAIR_BOX_BOX, NONE_ENABLED,
                        0, 0, 512, 512, 0, 0, 512, 512));
    send_pair(make_pair(bco_pkg::PAIR_BOX_CIRCLE, FIRST_ENABLED,
                        0, 0, 512, 512, 0, 0, 512, 0));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, SECOND_ENABLED,
                        0, 0, 512, 0, 0, 0, 512, 0));
    // Boxes: overlapping, touching edges, zero width, zero height.
    send_pair(make_pair(bco_pkg::PAIR_BOX_BOX, BOTH_ENABLED,
                        0, 0, 512, 512, 300, 0, 512, 512));
    send_pair(make_pair(bco_pkg::PAIR_BOX_BOX, BOTH_ENABLED,
                        0, 0, 512, 512, 512, 0, 512, 512));
    send_pair(make_pair(bco_pkg::PAIR_BOX_BOX, BOTH_ENABLED,
                        0, 0, 0, 512, 0, 0, 512, 512));
    send_pair(make_pair(bco_pkg::PAIR_BOX_BOX, BOTH_ENABLED,
                        0, 0, 512, 0, 0, 0, 512, 512));
    // Circle just touching a box edge, then just off it.
    send_pair(make_pair(bco_pkg::PAIR_BOX_CIRCLE, BOTH_ENABLED,
                        0, 0, 512, 512, 356, 0, 100, 0));
    send_pair(make_pair(bco_pkg::PAIR_BOX_CIRCLE, BOTH_ENABLED,
                        0, 0, 512, 512, 357, 0, 100, 0));
    // Circle against a box corner, in both orders; a circle's height is ignored.
    send_pair(make_pair(bco_pkg::PAIR_BOX_CIRCLE, BOTH_ENABLED,
                        0, 0, 512, 512, 286, 296, 50, 0));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_BOX, BOTH_ENABLED,
                        -286, -296, 49, 0, 0, 0, 512, 512));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_BOX, BOTH_ENABLED,
                        -286, -296, 50, 1048575, 0, 0, 512, 512));
    // Zero radius circle inside a box.
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_BOX, BOTH_ENABLED,
                        10, -20, 0, 0, 0, 0, 512, 512));
    // Tangent circles, a hair apart, and coincident points.
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, BOTH_ENABLED,
                        0, 0, 200, 0, 300, 400, 300, 0));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, BOTH_ENABLED,
                        0, 0, 200, 0, 300, 400, 299, 0));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, BOTH_ENABLED,
                        5, 5, 0, 0, 5, 5, 0, 0));
    // Far apart along one axis only.
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, BOTH_ENABLED,
                        0, 0, 100, 0, 1000, 0, 100, 0));
    // Extreme coordinates and extents.
    send_pair(make_pair(bco_pkg::PAIR_BOX_CIRCLE, BOTH_ENABLED,
                        -8388608, -8388608, 1048575, 1048575,
                        8388607, 8388607, 1048575, 1048575));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, BOTH_ENABLED,
                        8388607, 8388607, 1048575, 0,
                        8388607, -8388608, 1048575, 0));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_CIRCLE, BOTH_ENABLED,
                        -8388608, 8388607, 1048575, 1048575,
                        -6291458, 8388607, 1048575, 1048575));
    send_pair(make_pair(bco_pkg::PAIR_BOX_BOX, BOTH_ENABLED,
                        8388607, -8388608, 1048575, 1048575,
                        7340033, -8388608, 1048575, 1048575));
    send_pair(make_pair(bco_pkg::PAIR_CIRCLE_BOX, BOTH_ENABLED,
                        8388607, 8388607, 1048575, 0,
                        7864319, 8388607, 0, 0));
    wait_results_drained();
  endtask

  task automatic run_random_pairs(int count);
    repeat (count) send_pair(rand_pair());
  endtask

  task automatic test_stream_no_idle();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_random_pairs(PHASE_LEN);
  endtask

  task automatic test_stream_sender_idle();
    sender_idle_pct = 76;
    recv_stall_pct  = 0;
    run_random_pairs(PHASE_LEN / 2);
    // Let the pipeline empty completely before resuming.
    wait_results_drained();
    run_random_pairs(PHASE_LEN / 2);
  endtask

  task automatic test_stream_receiver_stall();
    sender_idle_pct = 0;
    recv_stall_pct  = 76;
    run_random_pairs(PHASE_LEN);
  endtask

  task automatic test_stream_both_idle();
    sender_idle_pct = 12;
    recv_stall_pct  = 12;
    run_random_pairs(PHASE_LEN);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYC) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_stream_no_idle();
    test_stream_sender_idle();
    test_stream_receiver_stall();
    test_stream_both_idle();
    wait_results_drained();
    // Any stray beat after the last expected one still gets caught.
    repeat (bco_pkg::NUM_STAGES + 4) @(negedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

### box_circle_overlap_test.f
design/bco_pkg.sv
design/bco_geom.sv
design/bco_dist.sv
design/box_circle_overlap_test.sv
dv/tb.sv
